// ===== design/csq_pkg.sv =====
package csq_pkg;

  localparam int DIGIT_BITS     = 28;
  localparam int MAX_DIGITS_DEF = 32;
  localparam int IDX_MAX_W      = 5;
  localparam int CNT_MAX_W      = 6;
  localparam int USED_W         = 7;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;
  localparam int PROD_W         = 2 * DIGIT_BITS;
  localparam int ACC_W          = 3 * DIGIT_BITS;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] digit;
    logic                  last_digit;
  } csq_in_t;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] result_digit;
    logic                  result_last;
    logic [USED_W-1:0]     used_digits;
    logic                  overflow;
  } csq_out_t;

  // One classified digit on its way from the front to the back.
  typedef struct packed {
    logic [DIGIT_BITS-1:0] digit;
    logic                  wr_en;
    logic [IDX_MAX_W-1:0]  wr_idx;
    logic                  last;
    logic [CNT_MAX_W-1:0]  count;
    logic                  ovf;
  } csq_entry_t;

  typedef struct packed {
    logic valid;
    logic dbl;
  } csq_mreq_t;

  typedef struct packed {
    logic              valid;
    logic              dbl;
    logic [PROD_W-1:0] product;
  } csq_mres_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COL_INIT,
    S_ISSUE,
    S_DRAIN
  } csq_state_t;

endpackage

// ===== design/csq_front.sv =====
module csq_front
  import csq_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  csq_in_t    in_data,
  input  logic       q_full,
  output logic       q_push,
  output csq_entry_t q_entry
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_after;
  logic             ovf_r, ovf_nxt;
  logic             keep;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign keep     = cnt_r < CNT_W'(MAX_DIGITS);
  assign cnt_after = keep ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    q_entry.digit  = in_data.digit;
    q_entry.wr_en  = keep;
    q_entry.wr_idx = IDX_MAX_W'(cnt_r);
    q_entry.last   = in_data.last_digit;
    q_entry.count  = CNT_MAX_W'(cnt_after);
    q_entry.ovf    = ovf_r || !keep;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (q_push) begin
      if (in_data.last_digit) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_after;
        ovf_nxt = ovf_r || !keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ===== design/csq_queue.sv =====
module csq_queue
  import csq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  csq_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output csq_entry_t head_entry
);

  csq_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full       = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

// ===== design/csq_mul.sv =====
module csq_mul
  import csq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  csq_mreq_t             req,
  input  logic [DIGIT_BITS-1:0] op_a,
  input  logic [DIGIT_BITS-1:0] op_b,
  output csq_mres_t             res
);

  logic              valid_r, dbl_r;
  logic [PROD_W-1:0] product_r;

  always_ff @(posedge clk) begin
    product_r <= PROD_W'(op_a) * PROD_W'(op_b);
    dbl_r     <= req.dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= req.valid;
    end
  end

  always_comb begin
    res.valid   = valid_r;
    res.dbl     = dbl_r;
    res.product = product_r;
  end

endmodule

// ===== design/csq_back.sv =====
module csq_back
  import csq_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  csq_entry_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output csq_out_t   out_data
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int COL_W = $clog2(2 * MAX_DIGITS + 1);

  logic [DIGIT_BITS-1:0] store_mem [MAX_DIGITS];

  csq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              ovf_r, ovf_nxt;
  logic [COL_W-1:0]  col_r, col_nxt, i_r, i_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [USED_W-1:0] top_r, top_nxt;
  logic              out_valid_r, out_valid_nxt;
  csq_out_t          out_data_r, out_data_nxt;

  logic                  st_we;
  logic [IDX_W-1:0]      rd_addr_a, rd_addr_b;
  logic [DIGIT_BITS-1:0] rd_a_r, rd_b_r;
  logic                  rd_v_r, rd_dbl_r;
  csq_mreq_t             issue, mreq;
  csq_mres_t             mres;

  logic [COL_W-1:0]      n_m1, j_idx;
  logic [COL_W:0]        col_inc, total;
  logic [PROD_W:0]       addend;
  logic [DIGIT_BITS-1:0] low_digit;
  logic [USED_W-1:0]     top_now;
  logic                  is_last, emit;

  assign n_m1      = COL_W'(n_r) - COL_W'(1);
  assign j_idx     = col_r - i_r;
  assign col_inc   = {1'b0, col_r} + (COL_W + 1)'(1);
  assign total     = (COL_W + 1)'({n_r, 1'b0});
  assign is_last   = col_inc == total;
  assign low_digit = acc_r[DIGIT_BITS-1:0];
  assign top_now   = (low_digit != '0) ? USED_W'(col_inc) : top_r;
  assign addend    = mres.dbl ? {mres.product, 1'b0} : {1'b0, mres.product};
  assign rd_addr_a = i_r[IDX_W-1:0];
  assign rd_addr_b = j_idx[IDX_W-1:0];
  assign st_we     = q_pop && q_head.wr_en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    col_nxt       = col_r;
    i_nxt         = i_r;
    acc_nxt       = acc_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    issue         = '0;
    emit          = 1'b0;
    if (mres.valid) begin
      acc_nxt = acc_r + ACC_W'(addend);
    end
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.last) begin
            n_nxt     = q_head.count[CNT_W-1:0];
            ovf_nxt   = q_head.ovf;
            col_nxt   = '0;
            acc_nxt   = '0;
            top_nxt   = '0;
            state_nxt = S_COL_INIT;
          end
        end
      end
      S_COL_INIT: begin
        i_nxt     = (col_r > n_m1) ? col_r - n_m1 : '0;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        if (i_r < j_idx) begin
          issue.valid = 1'b1;
          issue.dbl   = 1'b1;
          i_nxt       = i_r + COL_W'(1);
        end else if (i_r == j_idx) begin
          issue.valid = 1'b1;
          state_nxt   = S_DRAIN;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        emit = !rd_v_r && !mres.valid && (!out_valid_r || out_ready);
        if (emit) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.result_digit = low_digit;
          out_data_nxt.result_last  = is_last;
          out_data_nxt.used_digits  = is_last ? top_now : '0;
          out_data_nxt.overflow     = ovf_r;
          top_nxt                   = top_now;
          acc_nxt                   = acc_r >> DIGIT_BITS;
          col_nxt                   = COL_W'(col_inc);
          state_nxt                 = is_last ? S_IDLE : S_COL_INIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[q_head.wr_idx[IDX_W-1:0]] <= q_head.digit;
    end
    rd_a_r <= store_mem[rd_addr_a];
    rd_b_r <= store_mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    rd_dbl_r   <= issue.dbl;
    n_r        <= n_nxt;
    ovf_r      <= ovf_nxt;
    i_r        <= i_nxt;
    acc_r      <= acc_nxt;
    top_r      <= top_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      rd_v_r      <= issue.valid;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign mreq.valid = rd_v_r;
  assign mreq.dbl   = rd_dbl_r;

  csq_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .op_a  (rd_a_r),
    .op_b  (rd_b_r),
    .res   (mres)
  );

`ifndef SYNTHESIS
  a_used_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.result_last |-> out_data_r.used_digits == '0)
    else $error("digit count shown on a result that is not the last");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !rd_v_r && !mres.valid)
    else $error("products in flight while idle");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE && q_valid)
    else $error("queue read while a square is being formed");
`endif

endmodule

// ===== design/comba_bignum_squarer_top.sv =====
// Digits are taken one per cycle while the four-entry queue has room.
// After the last of n digits, each column passes S_COL_INIT, then S_ISSUE, which feeds
// the single shared 28x28 multiplier, then S_DRAIN; n(n+1)/2 products in all.
// Reset is synchronous and active low; it clears control state only, and the
// operand store holds no defined value until written.
module comba_bignum_squarer_top
  import csq_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  csq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output csq_out_t out_data
);

  logic       q_full, q_push, q_pop, q_valid;
  csq_entry_t q_entry, q_head;

  csq_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  csq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  csq_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_comba_bignum_squarer_top.sv =====
`timescale 1ns / 100ps

module tb_comba_bignum_squarer_top;
  import csq_pkg::*;

  localparam int ITEM_TARGET   = 450;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT       = 200;
  localparam int IDLE_PCT      = 28;
  localparam int DRAIN_CYCLES  = 60;
  localparam int MAX_REPORTS   = 60;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] digit;
    logic                  last;
    logic                  typed;
    logic [DIGIT_BITS-1:0] sq_lo;
    logic [DIGIT_BITS-1:0] sq_hi;
    logic [USED_W-1:0]     used;
  } digit_row_t;

  localparam int NUM_DIRECTED = 20;
  localparam digit_row_t DIRECTED [NUM_DIRECTED] = '{
    '{28'h0000000, 1'b1, 1'b1, 28'h0000000, 28'h0000000, 7'd0},
    '{28'h0000001, 1'b1, 1'b1, 28'h0000001, 28'h0000000, 7'd1},
    '{28'hFFFFFFF, 1'b1, 1'b1, 28'h0000001, 28'hFFFFFFE, 7'd2},
    '{28'h0000001, 1'b0, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h0000001, 1'b1, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'hFFFFFFF, 1'b0, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'hFFFFFFF, 1'b1, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'hAAAAAAA, 1'b0, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h5555555, 1'b0, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'hAAAAAAA, 1'b1, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h0000000, 1'b0, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h0000000, 1'b0, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h0000000, 1'b1, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h0000000, 1'b0, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h8000000, 1'b1, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h1234567, 1'b0, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h0000000, 1'b0, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'hFEDCBA9, 1'b0, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h0000000, 1'b1, 1'b0, 28'h0, 28'h0, 7'd0},
    '{28'h8000000, 1'b1, 1'b1, 28'h0000000, 28'h4000000, 7'd2}
  };

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  csq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  csq_out_t out_data;

  logic [DIGIT_BITS-1:0] held_digits [MAX_DIGITS_DEF];
  int                    held_count = 0;
  logic                  held_ovf   = 1'b0;
  csq_out_t              fresh_cols [$];
  csq_out_t              square_due [$];

  int  errors          = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  quiet_cycles    = 0;
  bit  sender_calm     = 1'b0;
  bit  receiver_calm   = 1'b0;

  comba_bignum_squarer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    if (errors < MAX_REPORTS) begin
      $display("square digit %0d: %s got 0x%0h expected 0x%0h",
               results_checked, what, got, want);
    end
    errors++;
  endtask

  // Stores one digit and, on the most significant one, forms every column of
  // the square with a wide accumulator that shifts down one digit per column.
  task automatic absorb_digit(input csq_in_t item);
    logic [ACC_W-1:0]  column;
    logic [PROD_W-1:0] prod;
    int                n;
    int                first;
    int                top;
    csq_out_t          res;
    fresh_cols.delete();
    if (held_count < MAX_DIGITS_DEF) begin
      held_digits[held_count] = item.digit;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (item.last_digit) begin
      n = held_count;
      column = '0;
      top = 0;
      for (int c = 0; c < 2 * n; c++) begin
        first = (c > n - 1) ? c - (n - 1) : 0;
        for (int i = first; i < c - i; i++) begin
          prod = PROD_W'(held_digits[i]) * PROD_W'(held_digits[c - i]);
          column += ACC_W'(prod) << 1;
        end
        if (c % 2 == 0) begin
          prod = PROD_W'(held_digits[c / 2]) * PROD_W'(held_digits[c / 2]);
          column += ACC_W'(prod);
        end
        if (column[DIGIT_BITS-1:0] != '0) begin
          top = c + 1;
        end
        res.result_digit = column[DIGIT_BITS-1:0];
        res.result_last  = (c == 2 * n - 1);
        res.used_digits  = (c == 2 * n - 1) ? USED_W'(top) : '0;
        res.overflow     = held_ovf;
        fresh_cols.push_back(res);
        column = column >> DIGIT_BITS;
      end
      held_count = 0;
      held_ovf   = 1'b0;
    end
  endtask

  task automatic offer_row(input digit_row_t row);
    csq_in_t  item;
    csq_out_t res;
    item.digit      = row.digit;
    item.last_digit = row.last;
    while (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_digit(item);
    if (row.typed) begin
      res = '{result_digit: row.sq_lo, result_last: 1'b0, used_digits: '0, overflow: 1'b0};
      square_due.push_back(res);
      res = '{result_digit: row.sq_hi, result_last: 1'b1, used_digits: row.used,
              overflow: 1'b0};
      square_due.push_back(res);
    end else begin
      foreach (fresh_cols[k]) square_due.push_back(fresh_cols[k]);
    end
    items_sent++;
  endtask

  function automatic logic [DIGIT_BITS-1:0] pick_digit();
    unique case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return DIGIT_BITS'($urandom_range(15));
      3: return {4'($urandom_range(15)), {(DIGIT_BITS-4){1'b0}}};
      4: return ~DIGIT_BITS'($urandom_range(15));
      default: return DIGIT_BITS'($urandom);
    endcase
  endfunction

  task automatic send_number(input int len, input bit all_max);
    digit_row_t row;
    for (int d = 0; d < len; d++) begin
      row       = '0;
      row.digit = all_max ? '1 : pick_digit();
      row.last  = (d == len - 1);
      offer_row(row);
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(4, 1);
    if (r < 85) return $urandom_range(12, 5);
    if (r < 95) return $urandom_range(32, 13);
    return $urandom_range(38, 33);
  endfunction

  initial begin
    int numbers;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      offer_row(DIRECTED[r]);
    end

    send_number(MAX_DIGITS_DEF, 1'b1);
    send_number(MAX_DIGITS_DEF + 3, 1'b0);

    numbers = 0;
    while (items_sent < ITEM_TARGET) begin
      if (numbers == 25) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (square_due.size() != 0);
      end
      sender_calm = (numbers >= 40 && numbers < 55);
      send_number(pick_length(), 1'b0);
      numbers++;
    end
    sender_calm = 1'b0;
    in_valid <= 1'b0;

    while (square_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && square_due.size() == 0) begin
      $display("comba_bignum_squarer_top: match");
    end else begin
      $display("comba_bignum_squarer_top: mismatch");
    end
    $finish;
  end

  // The receiver holds off once for a long stretch so that the block fills up.
  initial begin
    int  stall;
    bit  held_off;
    held_off = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && results_checked >= HOLD_AT) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        for (stall = 0; stall < HOLD_CYCLES; stall++) @(posedge clk);
      end else begin
        receiver_calm = (results_checked >= 400 && results_checked < 600);
        out_ready <= receiver_calm || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    csq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (square_due.size() == 0) begin
        flag_mismatch("transfer with nothing pending", out_data, 0);
      end else begin
        want = square_due.pop_front();
        if (out_data.result_digit !== want.result_digit) begin
          flag_mismatch("result_digit", out_data.result_digit, want.result_digit);
        end
        if (out_data.result_last !== want.result_last) begin
          flag_mismatch("result_last", out_data.result_last, want.result_last);
        end
        if (out_data.used_digits !== want.used_digits) begin
          flag_mismatch("used_digits", out_data.used_digits, want.used_digits);
        end
        if (out_data.overflow !== want.overflow) begin
          flag_mismatch("overflow", out_data.overflow, want.overflow);
        end
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("comba_bignum_squarer_top: mismatch");
      $finish;
    end
  end

endmodule
